>>> hdl/smi_pkg.sv
// Shared constants and helpers for the sprite motion interpolator.
// Used by smi_serdiv and sprite_motion_interpolator_unit; no dependencies.
`timescale 1ns / 1ps
package smi_pkg;

  // Fixed point: fraction bits of the per-frame step
  localparam int FRAC_BITS = 16;

  // Field widths
  localparam int POS_W  = 16;                 // pixel position, signed
  localparam int TILE_W = 8;                  // tile size
  localparam int IDX_W  = 10;                 // tile column / row index
  localparam int CNT_W  = 8;                  // frame counter, frame limit, divisor

  // Derived datapath widths
  localparam int TPX_W    = IDX_W + TILE_W;   // target pixel, unsigned
  localparam int DIFF_W   = TPX_W + 2;        // target minus position, signed
  localparam int MAG_W    = DIFF_W - 1;       // magnitude of the difference
  localparam int QUO_W    = MAG_W + FRAC_BITS;
  localparam int SUM_W    = QUO_W + 2;        // signed quotient plus residue
  localparam int WHOLE_W  = SUM_W - FRAC_BITS;
  localparam int RES_W    = FRAC_BITS + 1;
  localparam int NEWPOS_W = WHOLE_W + 1;
  localparam int DCNT_W   = $clog2(QUO_W);
  localparam int MCNT_W   = $clog2(TILE_W);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_MOVE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_START_X         = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_START_Y         = CFG_IDX_W'(4);

  // Reset values
  localparam logic [TILE_W-1:0] TILE_SIZE_RST  = TILE_W'(16);
  localparam logic [CNT_W-1:0]  FRAME_LIM_RST  = CNT_W'(8);

  localparam logic signed [NEWPOS_W-1:0] POS_MAX = NEWPOS_W'((1 << (POS_W - 1)) - 1);
  localparam logic signed [NEWPOS_W-1:0] POS_MIN = -POS_MAX - NEWPOS_W'(1);

  // Clamp a wide signed position into the pixel range
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [NEWPOS_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > POS_MAX) begin
      r = POS_MAX[POS_W-1:0];
    end else if (v < POS_MIN) begin
      r = POS_MIN[POS_W-1:0];
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/smi_serdiv.sv
// Two-lane bit-serial restoring divider, one quotient bit per lane per cycle.
// Depends on smi_pkg. Dividend is the magnitude shifted up by FRAC_BITS.
`timescale 1ns / 1ps
module smi_serdiv import smi_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] divisor,
  input  logic [MAG_W-1:0] dvd_x,
  input  logic [MAG_W-1:0] dvd_y,
  output logic             done,
  output logic [QUO_W-1:0] quot_x,
  output logic [QUO_W-1:0] quot_y
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  dsr_r, dsr_nxt;
  logic [CNT_W-1:0]  rem_r [2];
  logic [CNT_W-1:0]  rem_nxt [2];
  logic [QUO_W-1:0]  sh_r [2];
  logic [QUO_W-1:0]  sh_nxt [2];
  logic [CNT_W:0]    trial [2];
  logic [CNT_W:0]    diff [2];
  logic              ge [2];

  // Control: count QUO_W steps, pulse done after the last
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(QUO_W - 1);
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Datapath: shift one dividend bit into the remainder, trial subtract
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      trial[i]   = {rem_r[i], sh_r[i][QUO_W-1]};
      diff[i]    = trial[i] - {1'b0, dsr_r};
      ge[i]      = (trial[i] >= {1'b0, dsr_r});
      rem_nxt[i] = rem_r[i];
      sh_nxt[i]  = sh_r[i];
      if (start) begin
        rem_nxt[i] = '0;
      end else if (busy_r) begin
        rem_nxt[i] = ge[i] ? diff[i][CNT_W-1:0] : trial[i][CNT_W-1:0];
        sh_nxt[i]  = {sh_r[i][QUO_W-2:0], ge[i]};
      end
    end
    if (start) begin
      sh_nxt[0] = {dvd_x, {FRAC_BITS{1'b0}}};
      sh_nxt[1] = {dvd_y, {FRAC_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dsr_r <= dsr_nxt;
    for (int i = 0; i < 2; i++) begin
      rem_r[i] <= rem_nxt[i];
      sh_r[i]  <= sh_nxt[i];
    end
  end

  assign done   = done_r;
  assign quot_x = sh_r[0];
  assign quot_y = sh_r[1];

  // Remainders stay below the divisor while iterating
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r[0] < dsr_r) && (rem_r[1] < dsr_r))
    else $error("divider remainder not below divisor");

  // A new start never lands on a running division
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start)
    else $error("divider restarted while busy");

  // Done follows the last step
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("divider done without a finished run");

endmodule

>>> hdl/sprite_motion_interpolator_unit.sv
// Sprite motion interpolator top level: per-frame step toward a target tile.
// Depends on smi_pkg and smi_serdiv.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall): one transfer per frame tick, carrying
//   the target tile column and row. in_stall is high while an item is in work.
//   Result channel (out_valid / out_stall): one transfer per input, carrying
//   the new pixel position and the moving flag. A result sits in the output
//   register until taken; the next input is accepted meanwhile.
//   Config port (cfg_we / cfg_index / cfg_wdata): writes tile width, tile
//   height, frames per move, start x and start y. Start writes move the
//   position at once. Write only while the block is idle.
// Sequence:
//   Target pixel products are shift-add over TILE_W steps (8). An arrived or
//   snapped frame then passes S_DECIDE and S_OUT to reach the output register.
//   A moving frame runs the shared two-lane serial divider for QUO_W steps
//   (35) until its done pulse, then the sum, split and update stages before
//   S_OUT. The divider sets the rate. If the output register is still full,
//   the last stage waits for out_stall.
// Reset (synchronous, rst_n low): registers return to their reset values,
//   position to zero, counter and residues cleared, no result pending.
module sprite_motion_interpolator_unit import smi_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  // Input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [IDX_W-1:0]        in_target_col,
  input  logic [IDX_W-1:0]        in_target_row,
  // Result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] out_pixel_x,
  output logic signed [POS_W-1:0] out_pixel_y,
  output logic                    out_moving,
  // Configuration
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MUL    = 8'b0000_0010,
    S_DECIDE = 8'b0000_0100,
    S_DIV    = 8'b0000_1000,
    S_SUM    = 8'b0001_0000,
    S_SPLIT  = 8'b0010_0000,
    S_UPDATE = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration and motion state
  logic [TILE_W-1:0]        tile_width_r, tile_width_nxt;
  logic [TILE_W-1:0]        tile_height_r, tile_height_nxt;
  logic [CNT_W-1:0]         frames_per_move_r, frames_per_move_nxt;
  logic signed [POS_W-1:0]  pos_x_r, pos_x_nxt;
  logic signed [POS_W-1:0]  pos_y_r, pos_y_nxt;
  logic [CNT_W-1:0]         frame_count_r, frame_count_nxt;
  logic signed [RES_W-1:0]  residue_x_r, residue_x_nxt;
  logic signed [RES_W-1:0]  residue_y_r, residue_y_nxt;

  // Work registers
  logic [IDX_W-1:0]         col_r, col_nxt;
  logic [IDX_W-1:0]         row_r, row_nxt;
  logic [TILE_W-1:0]        msh_x_r, msh_x_nxt;
  logic [TILE_W-1:0]        msh_y_r, msh_y_nxt;
  logic [MCNT_W-1:0]        mul_cnt_r, mul_cnt_nxt;
  logic [TPX_W-1:0]         tpx_x_r, tpx_x_nxt;
  logic [TPX_W-1:0]         tpx_y_r, tpx_y_nxt;
  logic                     neg_x_r, neg_x_nxt;
  logic                     neg_y_r, neg_y_nxt;
  logic signed [SUM_W-1:0]  sum_x_r, sum_x_nxt;
  logic signed [SUM_W-1:0]  sum_y_r, sum_y_nxt;
  logic signed [WHOLE_W-1:0] whole_x_r, whole_x_nxt;
  logic signed [WHOLE_W-1:0] whole_y_r, whole_y_nxt;
  logic                     moving_r, moving_nxt;

  // Output register
  logic                     out_valid_r, out_valid_nxt;
  logic signed [POS_W-1:0]  out_pixel_x_r, out_pixel_x_nxt;
  logic signed [POS_W-1:0]  out_pixel_y_r, out_pixel_y_nxt;
  logic                     out_moving_r, out_moving_nxt;

  // Combinational helpers
  logic signed [DIFF_W-1:0]   dx, dy;
  logic [DIFF_W-1:0]          mag_x_full, mag_y_full;
  logic                       div_start, div_done;
  logic [CNT_W-1:0]           remaining;
  logic [QUO_W-1:0]           quot_x, quot_y;
  logic signed [SUM_W-1:0]    qs_x, qs_y;
  logic signed [SUM_W-1:0]    rnd_x, rnd_y;
  logic signed [SUM_W-1:0]    adj_x, adj_y;
  logic signed [NEWPOS_W-1:0] np_x, np_y;

  logic in_xfer, out_xfer;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;

  // Distance to target and its magnitude
  assign dx = $signed({2'b00, tpx_x_r}) - {{(DIFF_W - POS_W){pos_x_r[POS_W-1]}}, pos_x_r};
  assign dy = $signed({2'b00, tpx_y_r}) - {{(DIFF_W - POS_W){pos_y_r[POS_W-1]}}, pos_y_r};
  assign mag_x_full = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
  assign mag_y_full = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
  assign remaining  = frames_per_move_r - frame_count_r;

  assign div_start = (state_r == S_DECIDE) && !((dx == '0) && (dy == '0))
                     && (frame_count_r < frames_per_move_r);

  smi_serdiv u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (remaining),
    .dvd_x   (mag_x_full[MAG_W-1:0]),
    .dvd_y   (mag_y_full[MAG_W-1:0]),
    .done    (div_done),
    .quot_x  (quot_x),
    .quot_y  (quot_y)
  );

  // Signed quotient; rounding bias so the shift truncates toward zero
  always_comb begin
    qs_x = $signed({{(SUM_W - QUO_W){1'b0}}, quot_x});
    qs_y = $signed({{(SUM_W - QUO_W){1'b0}}, quot_y});
    if (neg_x_r) qs_x = -qs_x;
    if (neg_y_r) qs_y = -qs_y;
    rnd_x = $signed({{(SUM_W - FRAC_BITS){1'b0}}, {FRAC_BITS{sum_x_r[SUM_W-1]}}});
    rnd_y = $signed({{(SUM_W - FRAC_BITS){1'b0}}, {FRAC_BITS{sum_y_r[SUM_W-1]}}});
    adj_x = sum_x_r + rnd_x;
    adj_y = sum_y_r + rnd_y;
    np_x  = {{(NEWPOS_W - POS_W){pos_x_r[POS_W-1]}}, pos_x_r}
            + {whole_x_r[WHOLE_W-1], whole_x_r};
    np_y  = {{(NEWPOS_W - POS_W){pos_y_r[POS_W-1]}}, pos_y_r}
            + {whole_y_r[WHOLE_W-1], whole_y_r};
  end

  // Sequencer and state update
  always_comb begin
    state_nxt           = state_r;
    tile_width_nxt      = tile_width_r;
    tile_height_nxt     = tile_height_r;
    frames_per_move_nxt = frames_per_move_r;
    pos_x_nxt           = pos_x_r;
    pos_y_nxt           = pos_y_r;
    frame_count_nxt     = frame_count_r;
    residue_x_nxt       = residue_x_r;
    residue_y_nxt       = residue_y_r;
    col_nxt             = col_r;
    row_nxt             = row_r;
    msh_x_nxt           = msh_x_r;
    msh_y_nxt           = msh_y_r;
    mul_cnt_nxt         = mul_cnt_r;
    tpx_x_nxt           = tpx_x_r;
    tpx_y_nxt           = tpx_y_r;
    neg_x_nxt           = neg_x_r;
    neg_y_nxt           = neg_y_r;
    sum_x_nxt           = sum_x_r;
    sum_y_nxt           = sum_y_r;
    whole_x_nxt         = whole_x_r;
    whole_y_nxt         = whole_y_r;
    moving_nxt          = moving_r;
    out_valid_nxt       = out_valid_r && !out_xfer;
    out_pixel_x_nxt     = out_pixel_x_r;
    out_pixel_y_nxt     = out_pixel_y_r;
    out_moving_nxt      = out_moving_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          col_nxt     = in_target_col;
          row_nxt     = in_target_row;
          msh_x_nxt   = tile_width_r;
          msh_y_nxt   = tile_height_r;
          mul_cnt_nxt = MCNT_W'(TILE_W - 1);
          tpx_x_nxt   = '0;
          tpx_y_nxt   = '0;
          state_nxt   = S_MUL;
        end
      end
      // Shift-add, tile size MSB first
      S_MUL: begin
        tpx_x_nxt = {tpx_x_r[TPX_W-2:0], 1'b0}
                    + (msh_x_r[TILE_W-1] ? {{(TPX_W - IDX_W){1'b0}}, col_r} : '0);
        tpx_y_nxt = {tpx_y_r[TPX_W-2:0], 1'b0}
                    + (msh_y_r[TILE_W-1] ? {{(TPX_W - IDX_W){1'b0}}, row_r} : '0);
        msh_x_nxt   = {msh_x_r[TILE_W-2:0], 1'b0};
        msh_y_nxt   = {msh_y_r[TILE_W-2:0], 1'b0};
        mul_cnt_nxt = mul_cnt_r - MCNT_W'(1);
        if (mul_cnt_r == '0) state_nxt = S_DECIDE;
      end
      // Arrived, snap, or start the division
      S_DECIDE: begin
        moving_nxt = 1'b0;
        if ((dx == '0) && (dy == '0)) begin
          residue_x_nxt   = '0;
          residue_y_nxt   = '0;
          frame_count_nxt = '0;
          state_nxt       = S_OUT;
        end else if (frame_count_r >= frames_per_move_r) begin
          pos_x_nxt       = sat_pos({{(NEWPOS_W - TPX_W){1'b0}}, tpx_x_r});
          pos_y_nxt       = sat_pos({{(NEWPOS_W - TPX_W){1'b0}}, tpx_y_r});
          residue_x_nxt   = '0;
          residue_y_nxt   = '0;
          frame_count_nxt = '0;
          state_nxt       = S_OUT;
        end else begin
          neg_x_nxt = dx[DIFF_W-1];
          neg_y_nxt = dy[DIFF_W-1];
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) state_nxt = S_SUM;
      end
      // Step plus carried residue
      S_SUM: begin
        sum_x_nxt = qs_x + {{(SUM_W - RES_W){residue_x_r[RES_W-1]}}, residue_x_r};
        sum_y_nxt = qs_y + {{(SUM_W - RES_W){residue_y_r[RES_W-1]}}, residue_y_r};
        state_nxt = S_SPLIT;
      end
      // Whole part, truncated toward zero
      S_SPLIT: begin
        whole_x_nxt = adj_x[SUM_W-1:FRAC_BITS];
        whole_y_nxt = adj_y[SUM_W-1:FRAC_BITS];
        state_nxt   = S_UPDATE;
      end
      // New position, leftover fraction, counter
      S_UPDATE: begin
        pos_x_nxt       = sat_pos(np_x);
        pos_y_nxt       = sat_pos(np_y);
        residue_x_nxt   = sum_x_r[RES_W-1:0] - {whole_x_r[0], {FRAC_BITS{1'b0}}};
        residue_y_nxt   = sum_y_r[RES_W-1:0] - {whole_y_r[0], {FRAC_BITS{1'b0}}};
        frame_count_nxt = frame_count_r + CNT_W'(1);
        moving_nxt      = 1'b1;
        state_nxt       = S_OUT;
      end
      // Load the output register once it is free or its result is taken
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_pixel_x_nxt = pos_x_r;
          out_pixel_y_nxt = pos_y_r;
          out_moving_nxt  = moving_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Configuration writes
    if (cfg_we) begin
      case (cfg_index)
        REG_TILE_WIDTH:      tile_width_nxt      = cfg_wdata[TILE_W-1:0];
        REG_TILE_HEIGHT:     tile_height_nxt     = cfg_wdata[TILE_W-1:0];
        REG_FRAMES_PER_MOVE: frames_per_move_nxt = cfg_wdata[CNT_W-1:0];
        REG_START_X:         pos_x_nxt           = cfg_wdata[POS_W-1:0];
        REG_START_Y:         pos_y_nxt           = cfg_wdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      tile_width_r      <= TILE_SIZE_RST;
      tile_height_r     <= TILE_SIZE_RST;
      frames_per_move_r <= FRAME_LIM_RST;
      pos_x_r           <= '0;
      pos_y_r           <= '0;
      frame_count_r     <= '0;
      residue_x_r       <= '0;
      residue_y_r       <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      state_r           <= state_nxt;
      tile_width_r      <= tile_width_nxt;
      tile_height_r     <= tile_height_nxt;
      frames_per_move_r <= frames_per_move_nxt;
      pos_x_r           <= pos_x_nxt;
      pos_y_r           <= pos_y_nxt;
      frame_count_r     <= frame_count_nxt;
      residue_x_r       <= residue_x_nxt;
      residue_y_r       <= residue_y_nxt;
      out_valid_r       <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    col_r         <= col_nxt;
    row_r         <= row_nxt;
    msh_x_r       <= msh_x_nxt;
    msh_y_r       <= msh_y_nxt;
    mul_cnt_r     <= mul_cnt_nxt;
    tpx_x_r       <= tpx_x_nxt;
    tpx_y_r       <= tpx_y_nxt;
    neg_x_r       <= neg_x_nxt;
    neg_y_r       <= neg_y_nxt;
    sum_x_r       <= sum_x_nxt;
    sum_y_r       <= sum_y_nxt;
    whole_x_r     <= whole_x_nxt;
    whole_y_r     <= whole_y_nxt;
    moving_r      <= moving_nxt;
    out_pixel_x_r <= out_pixel_x_nxt;
    out_pixel_y_r <= out_pixel_y_nxt;
    out_moving_r  <= out_moving_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_pixel_x = out_pixel_x_r;
  assign out_pixel_y = out_pixel_y_r;
  assign out_moving  = out_moving_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_accept_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_MUL))
    else $error("accepted item did not start the multiply");

  a_count_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPDATE) |-> (frame_count_r < frames_per_move_r))
    else $error("step taken with the counter at or past the limit");

  a_residue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (residue_x_r != {1'b1, {FRAC_BITS{1'b0}}}) && (residue_y_r != {1'b1, {FRAC_BITS{1'b0}}}))
    else $error("residue reached a whole unit");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide phase");

endmodule
